FILE: rtl/core/mgp_pkg.sv
// Package: shared constants and register indexes for the MED/GAP pixel coder.
package mgp_pkg;
  localparam int unsigned PixW = 16;
  localparam int unsigned CfgW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPred = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDir = 2'd2;
  localparam logic [CfgIdxW-1:0] RegThresh = 2'd3;
  localparam logic [15:0] ThreshReset = 16'd80;
  localparam logic [16:0] PixMax = 17'd65535;

  // Neighbour set for one pixel.
  typedef struct packed {
    logic [PixW-1:0] w;
    logic [PixW-1:0] w2;
    logic [PixW-1:0] n;
    logic [PixW-1:0] nw;
    logic [PixW-1:0] ne;
    logic [PixW-1:0] n2;
    logic [PixW-1:0] ne2;
  } nbr_t;
endpackage

FILE: rtl/core/med_gap_predictive_pixel_coder.sv
// Top level: MED/GAP predictive pixel coder with two row memories.
// Result valid is registered: it rises in the cycle after the input transfer.
// Throughput: one pixel per cycle unless stalled; each transfer issues the
// memory read of the column after next; row starts use registered column 0.
// Reset (rst, synchronous): clears position, neighbours, registers to defaults;
// row memories are not cleared, entries are read only after being written.
module med_gap_predictive_pixel_coder #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample_in,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_value,
  output logic        row_end
);
  import mgp_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  logic [12:0] image_width;
  logic        predictor_select, direction;
  logic [15:0] gap_threshold;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd4096;
      predictor_select <= 1'b0;
      direction <= 1'b0;
      gap_threshold <= ThreshReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWidth:  image_width <= cfg_data[12:0];
        RegPred:   predictor_select <= cfg_data[0];
        RegDir:    direction <= cfg_data[0];
        RegThresh: gap_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective width, clamped to 1..MAX_WIDTH
  logic [CW:0] width;
  always_comb begin
    if (image_width == '0) width = (CW+1)'(1);
    else if (32'(image_width) > MAX_WIDTH) width = (CW+1)'(MAX_WIDTH);
    else width = (CW+1)'(image_width);
  end

  // position and neighbour registers
  logic [AW-1:0] column_count;
  logic [1:0]    row_count;
  logic [15:0]   left_pixel, left2_pixel, upper_left_pixel;
  // window: current column (n, n2) and copies of column 0 for the next row
  logic [15:0]   cur_n, cur_n2;
  logic [15:0]   col0_above, col0_two;
  // write data forwarded when the read hit the column written at that edge
  logic          fwd_hit;
  logic [15:0]   fwd_above, fwd_two;

  logic fire;
  assign in_ready = !rst && (!out_valid || out_ready);
  assign fire = in_valid && in_ready;

  logic [AW-1:0] x;
  logic [1:0]    y;
  assign x = frame_start ? '0 : column_count;
  assign y = frame_start ? 2'd0 : row_count;

  logic last;
  assign last = ((CW+1)'(x) + (CW+1)'(1)) >= width;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0]   rd_above, rd_two;
  logic          wr_en;
  logic [15:0]   pixel, ne_eff, ne2_eff;

  // memory read: the column after the next pixel's column; idle cycles
  // repeat the same address so the data stays current
  logic [AW-1:0] col_next;
  assign col_next = last ? '0 : x + AW'(1);
  assign rd_addr = fire ? col_next + AW'(1) : column_count + AW'(1);

  assign ne_eff = fwd_hit ? fwd_above : rd_above;
  assign ne2_eff = fwd_hit ? fwd_two : rd_two;

  nbr_t nb;
  always_comb begin
    nb.w = (x >= AW'(1)) ? left_pixel : '0;
    nb.w2 = (x >= AW'(2)) ? left2_pixel : '0;
    nb.n = (y >= 2'd1) ? cur_n : '0;
    nb.nw = (y >= 2'd1 && x >= AW'(1)) ? upper_left_pixel : '0;
    nb.ne = (y >= 2'd1 && !last) ? ne_eff : '0;
    nb.n2 = (y >= 2'd2) ? cur_n2 : '0;
    nb.ne2 = (y >= 2'd2 && !last) ? ne2_eff : '0;
  end

  logic [15:0] pred;
  mgp_predict u_pred (
    .nb(nb), .gap_sel(predictor_select), .thresh(gap_threshold), .pred(pred)
  );

  // residual coding, or decoding to the pixel when direction is set
  logic [15:0] r, v, res;
  always_comb begin
    r = sample_in - pred;
    v = (sample_in >> 1) ^ {16{sample_in[0]}};
    if (!direction) begin
      pixel = sample_in;
      res = {r[14:0], 1'b0} ^ {16{r[15]}};
    end else begin
      pixel = v + pred;
      res = pixel;
    end
  end

  assign wr_en = fire;
  assign wr_addr = x;

  mgp_line_store #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_line (
    .clk(clk), .rd_addr(rd_addr), .rd_above(rd_above), .rd_two(rd_two),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_above(pixel), .wr_two(nb.n)
  );

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      left_pixel <= '0;
      left2_pixel <= '0;
      upper_left_pixel <= '0;
      out_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fire) begin
        out_valid <= 1'b1;
        result_value <= res;
        row_end <= last;
        upper_left_pixel <= nb.n;
        left2_pixel <= left_pixel;
        left_pixel <= pixel;
        column_count <= col_next;
        if (last && y != 2'd2) row_count <= y + 2'd1;
        else row_count <= y;
        fwd_hit <= (rd_addr == wr_addr);
      end else begin
        fwd_hit <= 1'b0;
      end
    end
  end

  // column window: shift in the prefetched column, or restart at column 0
  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_above <= pixel;
      fwd_two <= nb.n;
      if (x == '0) begin
        col0_above <= pixel;
        col0_two <= nb.n;
      end
      if (last) begin
        cur_n <= (x == '0) ? pixel : col0_above;
        cur_n2 <= (x == '0) ? nb.n : col0_two;
      end else begin
        cur_n <= ne_eff;
        cur_n2 <= ne2_eff;
      end
    end
  end
endmodule

FILE: rtl/core/mgp_predict.sv
// Predictor: MED or GAP prediction from one neighbour set, combinational.
module mgp_predict (
  input  mgp_pkg::nbr_t      nb,
  input  logic               gap_sel,
  input  logic [15:0]        thresh,
  output logic [15:0]        pred
);
  import mgp_pkg::*;

  function automatic logic [16:0] adiff(input logic [15:0] a, input logic [15:0] b);
    adiff = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  logic signed [18:0] grad;
  logic [15:0] g;
  logic [16:0] ad1, ad2, ad3, av1, av2, av3;
  logic signed [19:0] dh, dv, dd;
  logic signed [19:0] th;
  logic signed [17:0] hsum;
  logic signed [17:0] qdiff;
  logic signed [18:0] gsum;
  logic [15:0] med, gap;

  // MED: median of n, w and clamped gradient
  always_comb begin
    grad = $signed({3'b0, nb.n}) + $signed({3'b0, nb.w}) - $signed({3'b0, nb.nw});
    if (grad < 0) g = '0;
    else if (grad > $signed({2'b0, PixMax})) g = 16'hFFFF;
    else g = grad[15:0];
    if ((nb.n > nb.w && nb.w > g) || (nb.n < nb.w && nb.w < g)) med = nb.w;
    else if ((nb.n > nb.w && nb.n > g) || (nb.n < nb.w && nb.n < g)) med = g;
    else med = nb.n;
  end

  // GAP: gradient test then blended estimate
  always_comb begin
    ad1 = adiff(nb.w2, nb.w);
    ad2 = adiff(nb.nw, nb.n);
    ad3 = adiff(nb.n, nb.ne);
    av1 = adiff(nb.w, nb.nw);
    av2 = adiff(nb.n, nb.n2);
    av3 = adiff(nb.ne2, nb.ne);
    dh = $signed({3'b0, ad1}) + $signed({3'b0, ad2}) + $signed({3'b0, ad3});
    dv = $signed({3'b0, av1}) + $signed({3'b0, av2}) + $signed({3'b0, av3});
    dd = dv - dh;
    th = $signed({4'b0, thresh});
    hsum = $signed({1'b0, ({1'b0, nb.w} + {1'b0, nb.n}) >> 1});
    qdiff = $signed({2'b0, nb.ne}) - $signed({2'b0, nb.nw});
    // truncate toward zero
    if (qdiff < 0) qdiff = -((-qdiff) >>> 2);
    else qdiff = qdiff >>> 2;
    gsum = $signed({hsum[17], hsum}) + $signed({qdiff[17], qdiff});
    if (dd > th) gap = nb.w;
    else if (dd < -th) gap = nb.n;
    else if (gsum < 0) gap = '0;
    else if (gsum > $signed({2'b0, PixMax})) gap = 16'hFFFF;
    else gap = gsum[15:0];
  end

  assign pred = gap_sel ? gap : med;
endmodule

FILE: rtl/core/mgp_line_store.sv
// Line store: two row memories, one write and one read port each, registered reads.
module mgp_line_store #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW = 12
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_above,
  output logic [15:0]   rd_two,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_above,
  input  logic [15:0]   wr_two
);
  logic [15:0] above_mem [MAX_WIDTH];
  logic [15:0] two_mem [MAX_WIDTH];

  // write port and registered read; a same-address read returns the old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_above;
      two_mem[wr_addr] <= wr_two;
    end
    rd_above <= above_mem[rd_addr];
    rd_two <= two_mem[rd_addr];
  end
endmodule

FILE: rtl/core/mgp_checker.sv
// Port checker for the pixel coder, bound to the top level.
module mgp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_value,
  input logic        row_end
);
  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(row_end))
    else $error("stalled result changed");
  // ready follows the output stage
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  // every input transfer gives a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid) else $error("result missing");
  // no result appears without a transfer
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready)) else $error("spurious result");
endmodule

bind med_gap_predictive_pixel_coder mgp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .result_value(result_value), .row_end(row_end)
);

FILE: tb/sv/med_gap_predictive_pixel_coder_tb.sv
// Testbench for the MED/GAP predictive pixel coder: directed and random frames vs a local model.
module med_gap_predictive_pixel_coder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mgp_pkg::*;

  typedef struct packed {
    logic [15:0] sample;
    logic        fs;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } coded_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] sample_in;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] result_value;
  logic        row_end;

  med_gap_predictive_pixel_coder u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .frame_start(frame_start), .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .row_end(row_end)
  );

  pixel_item_t   pending_pixels[$];
  coded_result_t expected_codes[$];
  int            error_count = 0;
  bit            calm = 0;
  bit            stall_request = 0;
  bit            in_xfer = 0;
  int            hold_cycles = 0;

  // Local copy of coder state and registers
  logic [15:0] above_row[4096];
  logic [15:0] two_above_row[4096];
  logic [15:0] west_px, west2_px, north_west_px;
  int          col_pos, row_pos;
  int          m_width, m_pred_gap, m_decode, m_thresh;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int sgn(input int v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic int clamp_px(input int v);
    return v < 0 ? 0 : (v > 65535 ? 65535 : v);
  endfunction

  function automatic int adiff(input int a, input int b);
    return a > b ? a - b : b - a;
  endfunction

  // Advance the local coder by one sample and return the result it should give
  function automatic coded_result_t code_pixel(input pixel_item_t it);
    int n, ne, nw, n2, ne2, w, w2, pred, raw_n, x, y, wd, g, dh, dv, d;
    logic [15:0] r, v, pix;
    coded_result_t res;
    n = 0; ne = 0; nw = 0; n2 = 0; ne2 = 0; w = 0; w2 = 0; raw_n = 0;
    if (it.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    wd = m_width;
    if (wd < 1) wd = 1;
    if (wd > 4096) wd = 4096;
    x = col_pos;
    y = row_pos;
    if (x >= 1) w = west_px;
    if (x >= 2) w2 = west2_px;
    if (y >= 1) begin
      raw_n = above_row[x];
      n = raw_n;
      if (x >= 1) nw = north_west_px;
      if (x + 1 < wd) ne = above_row[x+1];
    end
    if (y >= 2) begin
      n2 = two_above_row[x];
      if (x + 1 < wd) ne2 = two_above_row[x+1];
    end
    if (m_pred_gap != 0) begin
      dh = adiff(w2, w) + adiff(nw, n) + adiff(n, ne);
      dv = adiff(w, nw) + adiff(n, n2) + adiff(ne2, ne);
      d = dv - dh;
      if (d > m_thresh) pred = w;
      else if (d < -m_thresh) pred = n;
      else pred = clamp_px((w + n) / 2 + (ne - nw) / 4);
    end else begin
      // median edge detector with clamped gradient
      g = clamp_px(n + w - nw);
      if (sgn(n - w) * sgn(w - g) > 0) pred = w;
      else if (sgn(n - w) * sgn(n - g) > 0) pred = g;
      else pred = n;
    end
    if (m_decode == 0) begin
      r = it.sample - pred[15:0];
      pix = it.sample;
      res.value = {r[14:0], 1'b0} ^ {16{r[15]}};
    end else begin
      v = {1'b0, it.sample[15:1]} ^ {16{it.sample[0]}};
      pix = v + pred[15:0];
      res.value = pix;
    end
    two_above_row[x] = raw_n[15:0];
    above_row[x] = pix;
    north_west_px = raw_n[15:0];
    west2_px = west_px;
    west_px = pix;
    res.last = (x + 1 >= wd);
    if (res.last) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end else begin
      col_pos = x + 1;
    end
    return res;
  endfunction

  // Scoreboard: check output transfers, then predict for input transfers
  always @(posedge clk) begin
    coded_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{result_value, row_end};
      if (expected_codes.size() == 0) begin
        report($sformatf("unexpected result %h", result_value));
      end else begin
        want = expected_codes.pop_front();
        if (got.value !== want.value)
          report($sformatf("result_value %h, want %h", got.value, want.value));
        if (got.last !== want.last)
          report($sformatf("row_end %b, want %b", got.last, want.last));
      end
    end
    in_xfer = !rst && in_valid && in_ready;
    if (in_xfer) expected_codes.push_back(code_pixel('{sample_in, frame_start}));
  end

  // Sender: holds an offered sample until its transfer
  always @(negedge clk) begin
    pixel_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_xfer)) begin
      if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
        it = pending_pixels.pop_front();
        in_valid <= 1'b1;
        sample_in <= it.sample;
        frame_start <= it.fs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure plus one long hold-off on request
  always @(negedge clk) begin
    if (stall_request && hold_cycles == 0) begin
      stall_request = 0;
      hold_cycles = 300;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 26;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input int data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegWidth: m_width = data & 16'h1FFF;
      RegPred: m_pred_gap = data & 1;
      RegDir: m_decode = data & 1;
      RegThresh: m_thresh = data & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Queue one frame: mostly smooth content with small steps (small values when decoding), some noise
  task automatic push_frame(input int count, input bit first_fs);
    int px;
    px = $urandom_range(65535);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        px = clamp_px(px + $urandom_range(40) - 20);
        if (m_decode != 0) px = $urandom_range(63);
      end else begin
        px = $urandom_range(65535);
      end
      pending_pixels.push_back('{px[15:0],
                               (i == 0 && first_fs) || ($urandom_range(99) < 2)});
    end
  endtask

  task automatic set_all(input int wd, input int pr, input int dr, input int th);
    cfg_write(RegWidth, wd);
    cfg_write(RegPred, pr);
    cfg_write(RegDir, dr);
    cfg_write(RegThresh, th);
  endtask

  initial begin
    int wd, th;
    int widths[8] = '{1, 2, 3, 5, 7, 16, 33, 0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegWidth;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_in = '0;
    frame_start = 1'b0;
    out_ready = 1'b0;
    col_pos = 0; row_pos = 0;
    west_px = '0; west2_px = '0; north_west_px = '0;
    m_width = 4096; m_pred_gap = 0; m_decode = 0; m_thresh = ThreshReset;
    foreach (above_row[i]) begin
      above_row[i] = '0;
      two_above_row[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes on a 4-wide image, both predictors, both directions
    for (int mode = 0; mode < 4; mode++) begin
      set_all(4, mode & 1, mode >> 1, (mode == 1) ? 0 : 65535);
      for (int i = 0; i < 12; i++)
        pending_pixels.push_back('{(i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h8001),
                                 i == 0});
      wait_drained();
    end

    // Random phases over many settings
    for (int p = 0; p < 14; p++) begin
      wd = (p < 8) ? widths[p] : $urandom_range(1, 40);
      case (p % 4)
        0: th = 0;
        1: th = 65535;
        2: th = $urandom_range(200);
        default: th = $urandom_range(65535);
      endcase
      set_all(wd, $urandom_range(1), $urandom_range(1), th);
      calm = (p == 5);
      if (p == 3) stall_request = 1;
      push_frame(80, 1);
      wait_drained();
    end
    calm = 0;

    // Width lowered in the middle of a row
    set_all(16, 1, 0, 20);
    push_frame(16 * 3 + 10, 1);
    wait_drained();
    cfg_write(RegWidth, 4);
    push_frame(30, 0);
    wait_drained();

    // Widest rows: register above the maximum, then the maximum itself
    set_all(8191, 0, 1, 80);
    push_frame(300, 1);
    wait_drained();
    set_all(4096, 1, 0, 80);
    push_frame(200, 1);
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_codes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
